/* sv/mbet_pkg.sv */
`timescale 1ns / 1ps

package mbet_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_REAL_ORIGIN     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_REAL_STEP       = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAG_ORIGIN     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_IMAG_STEP       = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_ITERATION_LIMIT = 3'd4;

	localparam logic signed [31:0] RESET_REAL_ORIGIN = -32'sd33554432;
	localparam logic signed [31:0] RESET_REAL_STEP   = 32'sd83886;
	localparam logic signed [31:0] RESET_IMAG_ORIGIN = 32'sd25165824;
	localparam logic signed [31:0] RESET_IMAG_STEP   = -32'sd83886;
	localparam logic [7:0]         RESET_LIMIT       = 8'd100;

	// 4.0 in Q8.24, compared against the floored sum of squares.
	localparam logic signed [41:0] ESCAPE_SQ = 42'sd67108864;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CR,
		ST_CI,
		ST_CZ,
		ST_I0,
		ST_I1,
		ST_I2,
		ST_I3,
		ST_I4,
		ST_I5,
		ST_I6,
		ST_I7,
		ST_I8,
		ST_I9,
		ST_I10,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] real_origin;
		logic signed [31:0] real_step;
		logic signed [31:0] imag_origin;
		logic signed [31:0] imag_step;
		logic [7:0]         iteration_limit;
	} cfg_t;

	typedef struct packed {
		logic [9:0] column;
		logic [9:0] row;
		logic [7:0] count;
		logic       in_set;
	} result_t;

	// Floor of a Q16.48 product to Q16.24 without saturation.
	function automatic logic signed [39:0] floor24(input logic signed [63:0] p);
		floor24 = $signed(p[63:24]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
		logic hi_same;
		hi_same = (x[43:31] == {13{x[31]}});
		if (hi_same) begin
			sat32 = x[31:0];
		end else if (x[43]) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = 32'sh7FFF_FFFF;
		end
	endfunction

endpackage

/* sv/mbet_mul.sv */
`timescale 1ns / 1ps

module mbet_mul (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod
);

	logic signed [63:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* sv/mbet_ctrl.sv */
`timescale 1ns / 1ps

module mbet_ctrl
	import mbet_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       start,
	input  logic [9:0] column,
	input  logic [9:0] row,
	output logic       ready,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res
);

	state_t state_q, state_d;

	logic signed [31:0] zr_q, zi_q, cr_q, ci_q, ar_q, ai_q, t_q;
	logic signed [39:0] acc_q;
	logic [7:0]         count_q;
	logic [9:0]         col_q, row_q;

	logic signed [31:0] op_a, op_b;
	logic signed [63:0] prod;
	logic signed [39:0] pf;
	logic signed [41:0] sq_sum;
	logic               escaped;
	logic signed [31:0] z5i;

	mbet_mul u_mul (
		.clk  (clk),
		.a    (op_a),
		.b    (op_b),
		.prod (prod)
	);

	assign pf      = floor24(prod);
	assign sq_sum  = 42'(acc_q) + 42'(pf);
	assign escaped = (sq_sum >= ESCAPE_SQ);
	assign z5i     = sat32(44'(acc_q) + 44'(pf));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op_a      = zr_q;
		op_b      = zr_q;
		ready     = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ready = 1'b1;
				if (start) begin
					state_d = ST_CR;
				end
			end
			ST_CR: begin
				op_a    = $signed({22'd0, col_q});
				op_b    = cfg.real_step;
				state_d = ST_CI;
			end
			ST_CI: begin
				op_a    = $signed({22'd0, row_q});
				op_b    = cfg.imag_step;
				state_d = ST_CZ;
			end
			ST_CZ: begin
				state_d = ST_I0;
			end
			ST_I0: begin
				if (count_q >= cfg.iteration_limit) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_I1;
				end
			end
			ST_I1: begin
				op_a    = zi_q;
				op_b    = zi_q;
				state_d = ST_I2;
			end
			ST_I2: begin
				op_b = zi_q;
				if (escaped) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_I3;
				end
			end
			ST_I3: begin
				op_a    = ar_q;
				op_b    = ar_q;
				state_d = ST_I4;
			end
			ST_I4: begin
				op_a    = ai_q;
				op_b    = ai_q;
				state_d = ST_I5;
			end
			ST_I5: begin
				op_a    = ar_q;
				op_b    = ai_q;
				state_d = ST_I6;
			end
			ST_I6: begin
				op_a    = ar_q;
				state_d = ST_I7;
			end
			ST_I7: begin
				op_a    = ai_q;
				op_b    = zi_q;
				state_d = ST_I8;
			end
			ST_I8: begin
				op_a    = ar_q;
				op_b    = zi_q;
				state_d = ST_I9;
			end
			ST_I9: begin
				op_a    = ai_q;
				state_d = ST_I10;
			end
			ST_I10: begin
				state_d = ST_I0;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Each state that loads a register from the product consumes the product issued by the state before it.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					col_q <= column;
					row_q <= row;
				end
			end
			ST_CI: begin
				cr_q <= sat32(44'(cfg.real_origin) + $signed(prod[43:0]));
			end
			ST_CZ: begin
				ci_q    <= sat32(44'(cfg.imag_origin) + $signed(prod[43:0]));
				zr_q    <= '0;
				zi_q    <= '0;
				count_q <= '0;
			end
			ST_I1, ST_I4, ST_I7, ST_I9: begin
				acc_q <= pf;
			end
			ST_I2, ST_I5: begin
				ar_q <= sat32(44'(acc_q) - 44'(pf));
			end
			ST_I3, ST_I6: begin
				ai_q <= sat32(44'(pf) + 44'(pf));
			end
			ST_I8: begin
				t_q <= sat32(44'(acc_q) - 44'(pf));
			end
			ST_I10: begin
				zr_q    <= sat32(44'(t_q) + 44'(cr_q));
				zi_q    <= sat32(44'(z5i) + 44'(ci_q));
				count_q <= count_q + 8'd1;
			end
			default: begin
			end
		endcase
	end

	assign res.column = col_q;
	assign res.row    = row_q;
	assign res.count  = count_q;
	assign res.in_set = (count_q == cfg.iteration_limit);

endmodule

/* sv/multibrot_escape_time_pixel.sv */
`timescale 1ns / 1ps

// Escape-time engine for the degree-5 multibrot set z = z^5 + c, in signed Q8.24
// fixed point. One pixel is in flight at a time: s_axis_tready is high only while
// the engine is idle. A pixel ends when it escapes or when its count reaches the
// iteration limit, and the result on m_axis reports that iteration count. The
// iteration loop uses the single 32 x 32 multiplier, which performs the ten real
// products of each iteration (z^2, z^4 and z^5) one per cycle. The finished result
// sits in an output register, so the next pixel is accepted while the previous one
// waits on m_axis_tready. The user must write configuration registers only while
// the block is idle; the block itself does not enforce it.
module multibrot_escape_time_pixel
	import mbet_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// column [9:0], row [19:10], zero [23:20]
	input  logic [23:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_column [9:0], out_row [19:10], iteration_count [27:20], red [35:28],
	// green [43:36], blue [51:44], zero [55:52]
	output logic [55:0]           m_axis_tdata,
	// inside_set [0]
	output logic [0:0]            m_axis_tuser
);

	cfg_t    cfg_q;
	result_t res;
	logic    res_valid, res_ready, start;
	logic    out_valid_q;
	logic [55:0] out_data_q;
	logic        out_in_set_q;
	logic [7:0]  red, green, blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.real_origin     <= RESET_REAL_ORIGIN;
			cfg_q.real_step       <= RESET_REAL_STEP;
			cfg_q.imag_origin     <= RESET_IMAG_ORIGIN;
			cfg_q.imag_step       <= RESET_IMAG_STEP;
			cfg_q.iteration_limit <= RESET_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_REAL_ORIGIN:     cfg_q.real_origin     <= $signed(cfg_wdata);
				REG_REAL_STEP:       cfg_q.real_step       <= $signed(cfg_wdata);
				REG_IMAG_ORIGIN:     cfg_q.imag_origin     <= $signed(cfg_wdata);
				REG_IMAG_STEP:       cfg_q.imag_step       <= $signed(cfg_wdata);
				REG_ITERATION_LIMIT: cfg_q.iteration_limit <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign start = s_axis_tvalid && s_axis_tready;

	mbet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.column    (s_axis_tdata[9:0]),
		.row       (s_axis_tdata[19:10]),
		.ready     (s_axis_tready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	assign red   = res.in_set ? 8'd0 : 8'({res.count, 3'd0} + {3'd0, res.count});
	assign green = res.in_set ? 8'd0 : 8'({res.count, 3'd0} - {3'd0, res.count});
	assign blue  = res.in_set ? 8'd0
		: 8'({res.count, 3'd0} + {1'b0, res.count, 2'd0} + {3'd0, res.count});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q   <= {4'd0, blue, green, red, res.count, res.row, res.column};
			out_in_set_q <= res.in_set;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_in_set_q;

endmodule

/* sv/mbet_chk.sv */
`timescale 1ns / 1ps

module mbet_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [23:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// The engine holds one pixel at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while a pixel is still in the engine");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result transaction changed");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[51:28] == 24'd0))
		else $error("pixel inside the set is not black");

	a_red_from_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |->
		(m_axis_tdata[35:28] == 8'(m_axis_tdata[27:20] * 8'd9)))
		else $error("red byte does not follow the iteration count");

	a_out_zero_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[55:52] == 4'd0))
		else $error("result padding bits are not zero");

endmodule

bind multibrot_escape_time_pixel mbet_chk u_mbet_chk (.*);

/* bench/multibrot_escape_time_pixel_tb.sv */
`timescale 1ns / 1ps

module multibrot_escape_time_pixel_tb;
	import mbet_pkg::*;

	localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [9:0] column;
		logic [9:0] row;
		logic [7:0] count;
		logic       in_set;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} shade_t;

	class escape_scoreboard;
		cfg_t   view;
		shade_t awaited[$];
		int     errors;

		function new();
			view.real_origin     = RESET_REAL_ORIGIN;
			view.real_step       = RESET_REAL_STEP;
			view.imag_origin     = RESET_IMAG_ORIGIN;
			view.imag_step       = RESET_IMAG_STEP;
			view.iteration_limit = RESET_LIMIT;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
			case (addr)
				REG_REAL_ORIGIN:     view.real_origin = data;
				REG_REAL_STEP:       view.real_step = data;
				REG_IMAG_ORIGIN:     view.imag_origin = data;
				REG_IMAG_STEP:       view.imag_step = data;
				REG_ITERATION_LIMIT: view.iteration_limit = data[7:0];
				default: ;
			endcase
		endfunction

		function longint clamp_q(longint x);
			if (x > 64'sd2147483647) begin
				return 64'sd2147483647;
			end
			if (x < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return x;
		endfunction

		// Q8.24 product; the arithmetic shift floors toward minus infinity.
		function longint mul_q(longint a, longint b);
			return (a * b) >>> 24;
		endfunction

		function void complex_mul(longint ar, longint ai, longint br, longint bi,
				output longint pr, output longint pi);
			pr = clamp_q(mul_q(ar, br) - mul_q(ai, bi));
			pi = clamp_q(mul_q(ar, bi) + mul_q(ai, br));
		endfunction

		function logic [7:0] escape_count(logic [9:0] col, logic [9:0] row);
			longint cr, ci, zr, zi, sr, si, fr, fi, pr, pi;
			int unsigned n;
			cr = clamp_q(longint'($signed(view.real_origin))
				+ longint'(col) * longint'($signed(view.real_step)));
			ci = clamp_q(longint'($signed(view.imag_origin))
				+ longint'(row) * longint'($signed(view.imag_step)));
			zr = 0;
			zi = 0;
			n = 0;
			while (n < view.iteration_limit) begin
				if (mul_q(zr, zr) + mul_q(zi, zi) >= longint'(ESCAPE_SQ)) begin
					break;
				end
				complex_mul(zr, zi, zr, zi, sr, si);
				complex_mul(sr, si, sr, si, fr, fi);
				complex_mul(fr, fi, zr, zi, pr, pi);
				zr = clamp_q(pr + cr);
				zi = clamp_q(pi + ci);
				n++;
			end
			return n[7:0];
		endfunction

		function void note_pixel(logic [9:0] col, logic [9:0] row);
			shade_t s;
			logic [7:0] n;
			n = escape_count(col, row);
			s.column = col;
			s.row = row;
			s.count = n;
			s.in_set = (n == view.iteration_limit);
			s.red = s.in_set ? 8'd0 : 8'(n * 9);
			s.green = s.in_set ? 8'd0 : 8'(n * 7);
			s.blue = s.in_set ? 8'd0 : 8'(n * 13);
			awaited.push_back(s);
		endfunction

		function void compare(string what, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
			end
		endfunction

		function void check_pixel(logic [55:0] data, logic [0:0] flag);
			shade_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected pixel, expected none, got column %0d row %0d",
					$time, data[9:0], data[19:10]);
				return;
			end
			want = awaited.pop_front();
			compare("column", 32'(want.column), 32'(data[9:0]));
			compare("row", 32'(want.row), 32'(data[19:10]));
			compare("iteration_count", 32'(want.count), 32'(data[27:20]));
			compare("red", 32'(want.red), 32'(data[35:28]));
			compare("green", 32'(want.green), 32'(data[43:36]));
			compare("blue", 32'(want.blue), 32'(data[51:44]));
			compare("inside_set", 32'(want.in_set), 32'(flag));
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [23:0]           s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [55:0]           m_axis_tdata;
	logic [0:0]            m_axis_tuser;

	escape_scoreboard sb = new();
	bit               sender_steady = 1'b0;
	int unsigned      pixels_seen = 0;

	always #5 clk = ~clk;

	multibrot_escape_time_pixel u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(20, 80);
	endfunction

	task automatic cfg_push(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_reg(addr, data);
	endtask

	task automatic load_view(input logic [31:0] ro, input logic [31:0] rs,
			input logic [31:0] io, input logic [31:0] istep, input logic [31:0] lim);
		cfg_push(REG_REAL_ORIGIN, ro);
		cfg_push(REG_REAL_STEP, rs);
		cfg_push(REG_UNUSED, $urandom());
		cfg_push(REG_IMAG_ORIGIN, io);
		cfg_push(REG_IMAG_STEP, istep);
		cfg_push(REG_ITERATION_LIMIT, lim);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [9:0] col, input logic [9:0] row);
		int unsigned gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, row, col};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_pixel(col, row);
	endtask

	task automatic send_random_pixel();
		logic [9:0] col, row;
		if ($urandom_range(0, 9) == 0) begin
			col = 10'($urandom_range(0, 1023));
			row = 10'($urandom_range(0, 1023));
		end else begin
			col = 10'($urandom_range(0, 799));
			row = 10'($urandom_range(0, 599));
		end
		send_pixel(col, row);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result side: random back-pressure, one long hold-off and one stretch without gaps.
	initial begin
		int unsigned gap;
		while (!arst_n) @(posedge clk);
		forever begin
			if (pixels_seen == 200) begin
				gap = 600;
			end else if (pixels_seen >= 400 && pixels_seen < 500) begin
				gap = 0;
			end else begin
				gap = pick_gap();
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_pixel(m_axis_tdata, m_axis_tuser);
			pixels_seen++;
		end
	end

	initial begin
		#150_000_000;
		$display("multibrot_escape_time_pixel: mismatch");
		$finish;
	end

	initial begin
		logic [31:0] lim;
		int unsigned items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default view: corners, centre, out-of-image coordinates and alternating bits.
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd799, 10'd599);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd400, 10'd300);
		send_pixel(10'd0, 10'd1023);
		send_pixel(10'd1023, 10'd0);
		send_pixel(10'd682, 10'd341);
		send_pixel(10'd341, 10'd682);
		drain();

		// A zero limit runs no iteration, so every pixel is inside.
		load_view(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		drain();

		// Saturated c at both extremes stops after one iteration: escape or a limit of one.
		load_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd255);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd5, 10'd7);
		drain();
		load_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd1023, 10'd1023);
		send_pixel(10'd3, 10'd9);
		drain();

		// c = 0 never escapes and runs to the full limit.
		load_view(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd255);
		send_pixel(10'd0, 10'd0);
		send_pixel(10'd800, 10'd600);
		drain();

		for (int k = 0; k < 7; k++) begin
			sender_steady = (k % 2 == 1);
			if (k == 0) begin
				load_view($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
				items = 110;
			end else begin
				if (k == 6) begin
					lim = $urandom_range(200, 255);
					items = 40;
				end else if (k == 5) begin
					lim = $urandom_range(1, 8);
					items = 130;
				end else begin
					lim = $urandom_range(1, 48);
					items = 130;
				end
				load_view(-$urandom_range(20000000, 36000000), $urandom_range(30000, 110000),
					$urandom_range(15000000, 30000000), -$urandom_range(30000, 110000), lim);
			end
			for (int i = 0; i < items; i++) begin
				send_random_pixel();
			end
			drain();
		end

		repeat (3000) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("multibrot_escape_time_pixel: match");
		end else begin
			$display("multibrot_escape_time_pixel: mismatch");
		end
		$finish;
	end

endmodule
